[design/melody_note_sequencer_defines.svh]
// Assertion macros shared by the melody note sequencer RTL.
`ifndef MELODY_NOTE_SEQUENCER_DEFINES_SVH
`define MELODY_NOTE_SEQUENCER_DEFINES_SVH

// Same-cycle implication, sampled on clock, off during reset.
`define MNS_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("melody_note_sequencer: same-cycle check failed");

// Next-cycle implication, sampled on clock, off during reset.
`define MNS_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("melody_note_sequencer: next-cycle check failed");

`endif

[design/mns_pkg.sv]
// Types and constants of the melody note sequencer.
`default_nettype none

package mns_pkg;

   localparam int SONG_DEPTH = 256;
   localparam int SONG_AW    = (SONG_DEPTH > 1) ? $clog2(SONG_DEPTH) : 1;

   localparam int WORD_W     = 16;
   localparam int IDX_W      = 9;
   localparam int DUR_W      = 10;
   localparam int TEMPO_W    = 8;
   localparam int ADDR_W     = 8;
   localparam int PADDR_W    = 4;
   localparam int PDATA_W    = 32;
   localparam int DIV_STEPS  = DUR_W;
   localparam int DIV_CNT_W  = $clog2(DIV_STEPS + 1);

   localparam logic [1:0] ACT_LOAD   = 2'd0;
   localparam logic [1:0] ACT_TICK   = 2'd1;
   localparam logic [1:0] ACT_START  = 2'd2;
   localparam logic [1:0] ACT_UNUSED = 2'd3;

   localparam logic [DUR_W-1:0] DURATION_SEED_RESET = DUR_W'(32);
   localparam logic [IDX_W-1:0] SONG_LENGTH_RESET   = IDX_W'(256);

   typedef enum logic [1:0] {
      CSR_DURATION_SEED = 2'd0,
      CSR_SONG_LENGTH   = 2'd1,
      CSR_PAUSE_CODE_A  = 2'd2,
      CSR_PAUSE_CODE_B  = 2'd3
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_TEMPO,
      ST_LEN,
      ST_TONE,
      ST_DIV,
      ST_DONE
   } seq_state_type;

   typedef struct packed {
      logic [1:0]        action;
      logic [ADDR_W-1:0] word_address;
      logic [WORD_W-1:0] word_value;
   } req_type;

   typedef struct packed {
      logic [WORD_W-1:0] tone_period;
      logic              tone_enabled;
      logic              note_loaded;
      logic              song_ended;
      logic              is_playing;
   } rsp_type;

endpackage

`default_nettype wire

[design/melody_note_sequencer.sv]
// Melody note sequencer: song store, tick sequencer and serial note-length divider.
// Flow: a load, a start, a stopped tick or an unused code goes from EXEC straight to DONE;
// a tempo-prescale tick adds TEMPO, a tick that reads a note length adds LEN, and one that
// loads a note adds TONE and DIV (three registered store reads plus a 10-step serial divider).
// Throughput: one request in flight; the next is accepted only after DONE, which response stalls hold.
// Reset clears the sequencer state and loads the configuration defaults; the song store is not cleared.
`default_nettype none

`include "melody_note_sequencer_defines.svh"

module melody_note_sequencer (
   input  wire                           clock,
   input  wire                           reset,
   input  wire                           req_valid,
   output logic                          req_ready,
   input  mns_pkg::req_type              req_payload,
   output logic                          rsp_valid,
   input  wire                           rsp_ready,
   output mns_pkg::rsp_type              rsp_payload,
   input  wire                           psel,
   input  wire                           penable,
   input  wire                           pwrite,
   input  wire  [mns_pkg::PADDR_W-1:0]   paddr,
   input  wire  [mns_pkg::PDATA_W-1:0]   pwdata,
   output logic [mns_pkg::PDATA_W-1:0]   prdata,
   output logic                          pready
);
   import mns_pkg::*;

   // configuration registers
   logic [DUR_W-1:0]  duration_seed_ff;
   logic [IDX_W-1:0]  song_length_ff;
   logic [WORD_W-1:0] pause_code_a_ff;
   logic [WORD_W-1:0] pause_code_b_ff;
   csr_index_type     csr_index;
   logic              csr_write;

   // sequencer state
   seq_state_type     state_ff, state_in;
   req_type           req_ff;
   logic [IDX_W-1:0]  note_index_ff;
   logic [DUR_W-1:0]  duration_ff;
   logic [TEMPO_W-1:0] tempo_ff;
   logic              playing_ff;
   logic              tone_on_ff;
   logic [WORD_W-1:0] period_ff;
   logic              loaded_ff;
   logic              ended_ff;
   logic [TEMPO_W-1:0] prescale_ff;
   logic [WORD_W-1:0] len_ff;

   // divider
   logic [DUR_W-1:0]     div_num_ff;
   logic [WORD_W-1:0]    div_rem_ff;
   logic [DIV_CNT_W-1:0] div_cnt_ff;
   logic [WORD_W:0]      div_shift;
   logic [WORD_W:0]      div_diff;
   logic                 div_bit;
   logic [DUR_W-1:0]     div_num_in;

   // song store
   logic [WORD_W-1:0] song_mem [SONG_DEPTH];
   logic [WORD_W-1:0] rd_q_ff;
   logic              rd_oob_ff;
   logic              mem_rd_en;
   logic [IDX_W-1:0]  mem_rd_idx;
   logic              mem_wr_en;
   logic [WORD_W-1:0] rd_word;

   // output register
   logic              rsp_valid_ff;
   rsp_type           rsp_payload_ff;
   logic              rsp_free;

   // effective values once the note index zero case is folded in
   logic              idx_zero;
   logic [IDX_W-1:0]  idx_eff;
   logic [TEMPO_W-1:0] tempo_eff;
   logic [IDX_W-1:0]  idx_next;
   logic [IDX_W-1:0]  idx_skip;

   assign pready    = 1'b1;
   assign csr_index = csr_index_type'(paddr[3:2]);
   assign csr_write = psel && penable && pwrite;

   assign rd_word   = rd_oob_ff ? '0 : rd_q_ff;
   assign rsp_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   assign idx_zero  = (note_index_ff == '0);
   assign idx_eff   = idx_zero ? IDX_W'(1) : note_index_ff;
   assign tempo_eff = idx_zero ? rd_word[TEMPO_W-1:0] : tempo_ff;
   assign idx_next  = note_index_ff + IDX_W'(1);
   assign idx_skip  = note_index_ff + IDX_W'(2);

   assign div_shift  = {div_rem_ff, div_num_ff[DUR_W-1]};
   assign div_diff   = div_shift - {1'b0, len_ff};
   assign div_bit    = (div_shift >= {1'b0, len_ff});
   assign div_num_in = {div_num_ff[DUR_W-2:0], div_bit};

   always_ff @(posedge clock) begin
      if (reset) begin
         duration_seed_ff <= DURATION_SEED_RESET;
         song_length_ff   <= SONG_LENGTH_RESET;
         pause_code_a_ff  <= '0;
         pause_code_b_ff  <= '0;
      end else if (csr_write && pready) begin
         case (csr_index)
            CSR_DURATION_SEED: duration_seed_ff <= pwdata[DUR_W-1:0];
            CSR_SONG_LENGTH:   song_length_ff   <= pwdata[IDX_W-1:0];
            CSR_PAUSE_CODE_A:  pause_code_a_ff  <= pwdata[WORD_W-1:0];
            CSR_PAUSE_CODE_B:  pause_code_b_ff  <= pwdata[WORD_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         CSR_DURATION_SEED: prdata = PDATA_W'(duration_seed_ff);
         CSR_SONG_LENGTH:   prdata = PDATA_W'(song_length_ff);
         CSR_PAUSE_CODE_A:  prdata = PDATA_W'(pause_code_a_ff);
         CSR_PAUSE_CODE_B:  prdata = PDATA_W'(pause_code_b_ff);
         default:           prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_wr_en) begin
         song_mem[SONG_AW'(req_ff.word_address)] <= req_ff.word_value;
      end
      if (mem_rd_en) begin
         rd_q_ff   <= song_mem[SONG_AW'(mem_rd_idx)];
         rd_oob_ff <= (32'(mem_rd_idx) >= SONG_DEPTH);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      req_ready  = 1'b0;
      mem_rd_en  = 1'b0;
      mem_rd_idx = '0;
      mem_wr_en  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            state_in = ST_DONE;
            if (req_ff.action == ACT_LOAD) begin
               mem_wr_en = (32'(req_ff.word_address) < SONG_DEPTH);
            end else if (req_ff.action == ACT_TICK && playing_ff) begin
               // fetch the tempo prescale word first
               mem_rd_en = 1'b1;
               state_in  = ST_TEMPO;
            end
         end
         ST_TEMPO: begin
            if (tempo_eff == '0) begin
               mem_rd_en  = 1'b1;
               mem_rd_idx = idx_eff;
               state_in   = ST_LEN;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_LEN: begin
            if (duration_ff == '0 && rd_word != '0) begin
               mem_rd_en  = 1'b1;
               mem_rd_idx = idx_next;
               state_in   = ST_TONE;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_TONE: begin
            state_in = ST_DIV;
         end
         ST_DIV: begin
            if (div_cnt_ff == DIV_CNT_W'(DIV_STEPS - 1)) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         note_index_ff <= '0;
         duration_ff   <= '0;
         tempo_ff      <= '0;
         playing_ff    <= 1'b0;
         tone_on_ff    <= 1'b0;
         period_ff     <= '0;
         loaded_ff     <= 1'b0;
         ended_ff      <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_ready && state_ff != ST_DONE) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  req_ff    <= req_payload;
                  loaded_ff <= 1'b0;
                  ended_ff  <= 1'b0;
               end
            end
            ST_EXEC: begin
               if (req_ff.action == ACT_START) begin
                  duration_ff   <= '0;
                  note_index_ff <= IDX_W'(1);
                  playing_ff    <= 1'b1;
                  tone_on_ff    <= 1'b1;
               end
            end
            ST_TEMPO: begin
               prescale_ff   <= rd_word[TEMPO_W-1:0];
               note_index_ff <= idx_eff;
               if (idx_zero) begin
                  duration_ff <= '0;
               end
               if (tempo_eff != '0) begin
                  tempo_ff <= tempo_eff - TEMPO_W'(1);
               end
            end
            ST_LEN: begin
               tempo_ff <= prescale_ff;
               if (duration_ff != '0) begin
                  duration_ff <= duration_ff - DUR_W'(1);
               end else if (rd_word != '0) begin
                  len_ff        <= rd_word;
                  note_index_ff <= idx_skip;
                  loaded_ff     <= 1'b1;
               end else if (idx_next >= song_length_ff) begin
                  // end of song: stop and rewind
                  note_index_ff <= '0;
                  playing_ff    <= 1'b0;
                  tone_on_ff    <= 1'b0;
                  ended_ff      <= 1'b1;
               end else begin
                  note_index_ff <= idx_next;
               end
            end
            ST_TONE: begin
               period_ff  <= rd_word;
               tone_on_ff <= !(rd_word == pause_code_a_ff || rd_word == pause_code_b_ff);
               div_num_ff <= duration_seed_ff;
               div_rem_ff <= '0;
               div_cnt_ff <= '0;
            end
            ST_DIV: begin
               div_num_ff <= div_num_in;
               div_rem_ff <= div_bit ? div_diff[WORD_W-1:0] : div_shift[WORD_W-1:0];
               div_cnt_ff <= div_cnt_ff + DIV_CNT_W'(1);
               if (div_cnt_ff == DIV_CNT_W'(DIV_STEPS - 1)) begin
                  duration_ff <= div_num_in;
               end
            end
            ST_DONE: begin
               if (rsp_free) begin
                  rsp_valid_ff                <= 1'b1;
                  rsp_payload_ff.tone_period  <= period_ff;
                  rsp_payload_ff.tone_enabled <= tone_on_ff;
                  rsp_payload_ff.note_loaded  <= loaded_ff;
                  rsp_payload_ff.song_ended   <= ended_ff;
                  rsp_payload_ff.is_playing   <= playing_ff;
               end
            end
            default: ;
         endcase
      end
   end

   `MNS_ASSERT_NOW(a_stopped_is_silent, !playing_ff, !tone_on_ff)
   `MNS_ASSERT_NOW(a_load_or_end, loaded_ff, !ended_ff)
   `MNS_ASSERT_NEXT(a_accept_starts, req_valid && req_ready, state_ff == ST_EXEC)
   `MNS_ASSERT_NEXT(a_done_delivers, state_ff == ST_DONE && rsp_free,
                    rsp_valid_ff && state_ff == ST_IDLE)
   `MNS_ASSERT_NOW(a_div_bound, state_ff == ST_DIV, div_cnt_ff < DIV_CNT_W'(DIV_STEPS))

endmodule

`default_nettype wire
